>>> hw/rtl/lirs_pkg.sv
// Shared types and constants for the linear interpolation resampler.
// Used by the register block, the mix unit, the top level and the checker.
package lirs_pkg;

  // Fixed field widths
  localparam int SAMPLE_W = 16;
  localparam int POS_W    = 14;
  localparam int STEP_W   = 18;
  localparam int WLEN_W   = 15;

  // Parameter defaults
  localparam int WINDOW_MAX_DEF      = 16384;
  localparam int PHASE_FRAC_BITS_DEF = 16;

  // Most outputs that one input sample may cause
  localparam int RUN_CAP   = 64;
  localparam int RUN_CNT_W = 7;

  // Register reset values
  localparam logic [STEP_W-1:0] PHASE_STEP_RST    = 18'd65283;
  localparam logic [WLEN_W-1:0] WINDOW_LENGTH_RST = 15'd16000;

  // Register indexes on the configuration port
  typedef enum logic {
    REG_PHASE_STEP    = 1'b0,
    REG_WINDOW_LENGTH = 1'b1
  } lirs_reg_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [STEP_W-1:0] phase_step;
    logic [WLEN_W-1:0] window_length;
  } lirs_cfg_t;

endpackage

>>> hw/rtl/lirs_cfg_regs.sv
// APB-style configuration registers for the linear interpolation resampler.
// Depends on lirs_pkg for register indexes, widths and reset values.
module lirs_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output lirs_pkg::lirs_cfg_t cfg
);
  import lirs_pkg::*;

  logic      wr_en;
  lirs_reg_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = lirs_reg_t'(paddr[2]);

  // Register writes complete in the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_step    <= PHASE_STEP_RST;
      cfg.window_length <= WINDOW_LENGTH_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_PHASE_STEP:    cfg.phase_step    <= pwdata[STEP_W-1:0];
        REG_WINDOW_LENGTH: cfg.window_length <= pwdata[WLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the selected register.
  always_comb begin
    case (reg_sel)
      REG_PHASE_STEP:    prdata = 32'(cfg.phase_step);
      REG_WINDOW_LENGTH: prdata = 32'(cfg.window_length);
      default:           prdata = 32'd0;
    endcase
  end

endmodule

>>> hw/rtl/lirs_mix_unit.sv
// Shared mix unit: one registered multiply of the sample difference by the
// phase fraction, then scaling, truncation toward zero and clamping.
// Depends on lirs_pkg for the sample width.
module lirs_mix_unit #(
  parameter int PHASE_FRAC_BITS = lirs_pkg::PHASE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                mul_en,
  input  logic signed [lirs_pkg::SAMPLE_W-1:0] prev,
  input  logic signed [lirs_pkg::SAMPLE_W:0]   diff,
  input  logic [PHASE_FRAC_BITS-1:0]          frac,
  output logic signed [lirs_pkg::SAMPLE_W-1:0] sample
);
  import lirs_pkg::*;

  localparam int PROD_W = SAMPLE_W + 1 + PHASE_FRAC_BITS + 1;
  localparam int NUM_W  = PROD_W + 1;
  localparam int Q_W    = NUM_W - PHASE_FRAC_BITS;

  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(32767);
  localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(32768);

  logic signed [PROD_W-1:0] prod;
  logic signed [NUM_W-1:0]  num;
  logic signed [Q_W-1:0]    q_floor;
  logic signed [Q_W-1:0]    q;

  // prev*(1-f) + cur*f is prev*one + (cur-prev)*f; only the product is stored.
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= diff * $signed({1'b0, frac});
    end
  end

  // Scale by one with truncation toward zero, then clamp to 16 bits.
  always_comb begin
    num     = (NUM_W'(prev) <<< PHASE_FRAC_BITS) + NUM_W'(prod);
    q_floor = num[NUM_W-1:PHASE_FRAC_BITS];
    q       = (num[NUM_W-1] && (|num[PHASE_FRAC_BITS-1:0])) ? q_floor + Q_W'(1) : q_floor;
    if (q > Q_MAX) begin
      sample = 16'sh7FFF;
    end else if (q < Q_MIN) begin
      sample = 16'sh8000;
    end else begin
      sample = q[SAMPLE_W-1:0];
    end
  end

endmodule

>>> hw/rtl/linear_interp_resampler_unit.sv
// Linear interpolation sample-rate converter: top level with the sequencer.
// Depends on lirs_pkg, lirs_cfg_regs and lirs_mix_unit.
//
// One input sample is taken at a time and s_tready stays low while it is
// worked on. Each output passes through the single shared multiplier
// path (multiply, then scale and clamp into the output register), and every
// input also passes through its accept, window check and phase update
// steps; a low m_tready holds a result until the output register is free.
// Inputs arriving after the window is full end at the window check and
// give nothing; a sample with tuser set restarts the window. Outputs carry
// the sample in m_tdata[15:0], the index within the window in m_tdata[29:16],
// and mark the last output caused by an input with m_tlast.
module linear_interp_resampler_unit #(
  parameter int WINDOW_MAX      = lirs_pkg::WINDOW_MAX_DEF,
  parameter int PHASE_FRAC_BITS = lirs_pkg::PHASE_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] in_sample
  input  logic        s_tuser,   // [0] start_window
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] out_sample, [29:16] out_position, [31:30] zero
  output logic        m_tlast,   // last_of_run
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lirs_pkg::*;

  localparam int PA_W    = ((PHASE_FRAC_BITS > STEP_W) ? PHASE_FRAC_BITS : STEP_W) + 1;
  localparam int LIM_MAX = (WINDOW_MAX < 32767) ? WINDOW_MAX : 32767;
  localparam int FILL_W  = $clog2(LIM_MAX + 1);

  localparam logic [PA_W-1:0] PHASE_ONE = PA_W'(1) << PHASE_FRAC_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_OUT,
    ST_FIN
  } state_t;

  state_t                       state;
  lirs_cfg_t                    cfg;
  logic signed [SAMPLE_W-1:0]   cur;
  logic signed [SAMPLE_W-1:0]   prev;
  logic signed [SAMPLE_W:0]     diff;
  logic [PA_W-1:0]              phase_acc;
  logic [SAMPLE_W-1:0]          prior_sample;
  logic                         prior_valid;
  logic [FILL_W-1:0]            window_fill;
  logic [RUN_CNT_W-1:0]         run_cnt;

  logic [FILL_W-1:0]            limit;
  logic signed [SAMPLE_W-1:0]   prev_sel;
  logic [PA_W-1:0]              phase_next;
  logic [FILL_W-1:0]            fill_next;
  logic [RUN_CNT_W-1:0]         run_cnt_next;
  logic                         run_last;
  logic                         mul_en;
  logic                         out_load;
  logic signed [SAMPLE_W-1:0]   mix_sample;

  lirs_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lirs_mix_unit #(
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_mix (
    .clk    (clk),
    .mul_en (mul_en),
    .prev   (prev),
    .diff   (diff),
    .frac   (phase_acc[PHASE_FRAC_BITS-1:0]),
    .sample (mix_sample)
  );

  // Window limit is the smaller of the register and the build-time maximum.
  always_comb begin
    if (32'(cfg.window_length) < 32'(WINDOW_MAX)) begin
      limit = FILL_W'(cfg.window_length);
    end else begin
      limit = FILL_W'(WINDOW_MAX);
    end
  end

  // The first sample of a window stands in as its own predecessor.
  assign prev_sel = prior_valid ? $signed(prior_sample) : cur;

  // Step values for the output being emitted and the test for another one.
  assign phase_next   = phase_acc + PA_W'(cfg.phase_step);
  assign fill_next    = window_fill + FILL_W'(1);
  assign run_cnt_next = run_cnt + RUN_CNT_W'(1);
  assign run_last     = !((phase_next < PHASE_ONE) && (fill_next < limit) &&
                          (run_cnt_next < RUN_CNT_W'(RUN_CAP)));

  assign mul_en   = (state == ST_MUL);
  assign s_tready = (state == ST_IDLE);

  // A result is loaded once the output register is free.
  assign out_load = (state == ST_OUT) && (!m_tvalid || m_tready);

  // Sequencer, state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      phase_acc    <= '0;
      prior_sample <= '0;
      prior_valid  <= 1'b0;
      window_fill  <= '0;
      run_cnt      <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      // The output register fills on a load and empties on a transfer.
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cur <= $signed(s_tdata);
            if (s_tuser) begin
              phase_acc    <= '0;
              prior_sample <= '0;
              prior_valid  <= 1'b0;
              window_fill  <= '0;
            end
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (window_fill >= limit) begin
            // Full window: the sample is dropped and nothing changes.
            state <= ST_IDLE;
          end else begin
            prev    <= prev_sel;
            diff    <= (SAMPLE_W + 1)'(cur) - (SAMPLE_W + 1)'(prev_sel);
            run_cnt <= '0;
            state   <= (phase_acc < PHASE_ONE) ? ST_MUL : ST_FIN;
          end
        end
        ST_MUL: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          // Load a result once the output register is free.
          if (out_load) begin
            m_tdata[15:0]           <= mix_sample;
            m_tdata[29:16]          <= POS_W'(window_fill);
            m_tdata[31:30]          <= 2'b00;
            m_tlast                 <= run_last;
            phase_acc               <= phase_next;
            window_fill             <= fill_next;
            run_cnt                 <= run_cnt_next;
            state                   <= run_last ? ST_FIN : ST_MUL;
          end
        end
        ST_FIN: begin
          // Drop one from the phase, saturating at zero, and keep the sample.
          phase_acc    <= (phase_acc >= PHASE_ONE) ? phase_acc - PHASE_ONE : '0;
          prior_sample <= cur;
          prior_valid  <= 1'b1;
          state        <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/lirs_checker.sv
// Port-level checks for the linear interpolation resampler, and the bind
// that attaches them to the top level. Depends on the top level's ports only.
module lirs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast,
  input logic        pready
);

  // An accepted sample keeps the block busy for at least the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted on two consecutive cycles");

  // More outputs are due after a transfer without tlast, so no new sample yet.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> !s_tready)
    else $error("input taken before the run's last output");

  // A stalled output holds its value.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled output changed");

  // The pad bits of the output word stay clear, and pready is high while output is valid.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[31:30] == 2'b00) && pready)
    else $error("output pad bits set or pready low");

endmodule

bind linear_interp_resampler_unit lirs_checker u_lirs_checker (.*);

>>> verif/lirs_resample_checker.sv
// Checker for the linear interpolation resampler: watches the register port and
// both streams, predicts every interpolated output and compares it on transfer.
// Depends on lirs_pkg.
`timescale 1ns / 100ps

module lirs_resample_checker #(
  parameter int WINDOW_MAX      = lirs_pkg::WINDOW_MAX_DEF,
  parameter int PHASE_FRAC_BITS = lirs_pkg::PHASE_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] in_sample
  input  logic        s_tuser,   // [0] start_window
  // Output stream
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // [15:0] out_sample, [29:16] out_position, [31:30] zero
  input  logic        m_tlast,   // last_of_run
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  // Status toward the testbench top
  output int unsigned mismatch_count,
  output int unsigned outputs_owed
);
  import lirs_pkg::*;

  localparam logic [STEP_W:0] PHASE_ONE  = {{STEP_W{1'b0}}, 1'b1} << PHASE_FRAC_BITS;
  localparam longint          SAMPLE_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint          SAMPLE_MIN = -(longint'(1) << (SAMPLE_W - 1));
  localparam int              REPORT_MAX = 10;

  // One interpolated output as it should leave the block.
  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    logic [POS_W-1:0]    position;
    logic                last;
  } interp_out_t;

  interp_out_t interp_q[$];

  // Register copies and resampler state.
  logic [STEP_W-1:0]   step_cfg;
  logic [WLEN_W-1:0]   wlen_cfg;
  logic [STEP_W:0]     phase;
  logic [SAMPLE_W-1:0] prior;
  logic                prior_ok;
  logic [WLEN_W-1:0]   fill;

  interp_out_t want;

  // Works out every output that one accepted input sample causes and queues it.
  function automatic void interpolate_sample(input logic [SAMPLE_W-1:0] raw,
                                             input logic restart);
    logic [SAMPLE_W-1:0] prev;
    longint one_l, wt, acc, quo;
    int unsigned limit, n;
    interp_out_t r;
    if (restart) begin
      phase    = '0;
      prior    = '0;
      prior_ok = 1'b0;
      fill     = '0;
    end
    limit = (int'(wlen_cfg) < WINDOW_MAX) ? int'(wlen_cfg) : WINDOW_MAX;
    // A full window swallows the sample without touching any state.
    if (int'(fill) >= limit) return;
    // The first sample of a window stands in for its own predecessor.
    prev  = prior_ok ? prior : raw;
    one_l = longint'(PHASE_ONE);
    n     = 0;
    while (phase < PHASE_ONE && int'(fill) < limit && n < RUN_CAP) begin
      wt  = longint'(phase);
      acc = longint'($signed(prev)) * (one_l - wt) + longint'($signed(raw)) * wt;
      quo = acc / one_l;
      if (quo > SAMPLE_MAX) quo = SAMPLE_MAX;
      else if (quo < SAMPLE_MIN) quo = SAMPLE_MIN;
      r.sample   = quo[SAMPLE_W-1:0];
      r.position = fill[POS_W-1:0];
      n++;
      fill  = fill + 1'b1;
      phase = phase + {1'b0, step_cfg};
      // The output that ends the run carries the last flag.
      r.last = !(phase < PHASE_ONE && int'(fill) < limit && n < RUN_CAP);
      interp_q.push_back(r);
    end
    // Drop one whole sample period; a phase still below one clamps to zero.
    phase    = (phase >= PHASE_ONE) ? phase - PHASE_ONE : '0;
    prior    = raw;
    prior_ok = 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      step_cfg       = PHASE_STEP_RST;
      wlen_cfg       = WINDOW_LENGTH_RST;
      phase          = '0;
      prior          = '0;
      prior_ok       = 1'b0;
      fill           = '0;
      mismatch_count = 0;
      interp_q.delete();
    end else begin
      // Register writes land at the access cycle.
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        case (lirs_reg_t'(paddr[2]))
          REG_PHASE_STEP:    step_cfg = pwdata[STEP_W-1:0];
          REG_WINDOW_LENGTH: wlen_cfg = pwdata[WLEN_W-1:0];
          default: ;
        endcase
      end

      // Each output transfer is held against the oldest prediction.
      if (m_tvalid && m_tready) begin
        if (interp_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("%0t: unexpected output: sample %0d position %0d last %0b", $time,
                     $signed(m_tdata[SAMPLE_W-1:0]), m_tdata[SAMPLE_W +: POS_W], m_tlast);
        end else begin
          want = interp_q.pop_front();
          if (m_tdata[SAMPLE_W-1:0] !== want.sample ||
              m_tdata[SAMPLE_W +: POS_W] !== want.position ||
              m_tlast !== want.last || m_tdata[31:SAMPLE_W+POS_W] !== '0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
              $display("%0t: output mismatch: expected sample %0d position %0d last %0b, %s",
                       $time, $signed(want.sample), want.position, want.last,
                       $sformatf("got sample %0d position %0d last %0b pad %0h",
                                 $signed(m_tdata[SAMPLE_W-1:0]), m_tdata[SAMPLE_W +: POS_W],
                                 m_tlast, m_tdata[31:SAMPLE_W+POS_W]));
          end
        end
      end

      // Input transfers feed the predictor.
      if (s_tvalid && s_tready) interpolate_sample(s_tdata, s_tuser);
    end
    outputs_owed = interp_q.size();
  end

endmodule

>>> verif/testbench.sv
// Testbench top for linear_interp_resampler_unit: drives samples and register
// writes with random idling and gives the verdict. Depends on lirs_pkg and
// lirs_resample_checker.
`timescale 1ns / 100ps

module testbench;
  import lirs_pkg::*;

  localparam logic NEW_WINDOW    = 1'b1;
  localparam logic SAME_WINDOW   = 1'b0;
  localparam int   SETTLE_CYCLES = 8;
  localparam int   HOLD_CYCLES   = 400;
  localparam int   RAND_PHASES   = 8;
  localparam int   PHASE_ITEMS   = 16;
  localparam int   DRAIN_LIMIT   = 50000;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;
  logic        s_tuser  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned mismatch_count;
  int unsigned outputs_owed;

  // Idling controls, changed between phases.
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned rx_hold_req  = 0;
  int unsigned rx_hold_left = 0;

  always #5 clk = ~clk;

  linear_interp_resampler_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  lirs_resample_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatch_count (mismatch_count),
    .outputs_owed   (outputs_owed)
  );

  // Output side: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Offers one sample and returns at the falling edge after its transfer.
  task automatic send_sample(input logic [15:0] smp, input logic restart);
    int unsigned gap;
    gap = 0;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tuser  <= restart;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops offering and waits until every predicted output has gone out.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (outputs_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input lirs_reg_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input logic [31:0] step, input logic [31:0] wlen);
    settle();
    write_reg(REG_PHASE_STEP, step);
    write_reg(REG_WINDOW_LENGTH, wlen);
  endtask

  // Mostly full-range samples, with extremes and quiet signals mixed in.
  function automatic logic [15:0] pick_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3:    return {{7{r[8]}}, r[8:0]};
      default: return r[15:0];
    endcase
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(7))
      0:       return $urandom_range(1023, 1);
      1:       return $urandom_range(8192, 1024);
      2:       return 32'd65536;
      3:       return $urandom_range(70000, 60000);
      4:       return $urandom_range(262143, 131072);
      default: return $urandom_range(262143, 1024);
    endcase
  endfunction

  function automatic logic [31:0] pick_wlen();
    case ($urandom_range(5))
      0:       return $urandom_range(8, 1);
      1:       return $urandom_range(300, 9);
      2:       return 32'd16384;
      3:       return $urandom_range(32767, 16385);
      default: return $urandom_range(16384, 1);
    endcase
  endfunction

  // Stimulus and verdict.
  initial begin
    int unsigned ph, k, waited;
    logic [31:0] step, wlen;

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: extremes, restart mid-stream, first sample of a window.
    send_sample(16'h7FFF, NEW_WINDOW);
    send_sample(16'h8000, SAME_WINDOW);
    send_sample(16'h7FFF, SAME_WINDOW);
    send_sample(16'h0000, SAME_WINDOW);
    send_sample(16'hFFFF, SAME_WINDOW);
    send_sample(16'h8000, NEW_WINDOW);
    send_sample(16'd12345, SAME_WINDOW);

    // Half step with a short window: fill it, feed an ignored sample, restart.
    configure(32'd32768, 32'd5);
    send_sample(16'd100, NEW_WINDOW);
    send_sample(-16'sd100, SAME_WINDOW);
    send_sample(16'h7FFF, SAME_WINDOW);
    send_sample(16'd555, SAME_WINDOW);
    send_sample(16'h8000, NEW_WINDOW);

    // Zero window length yields nothing.
    configure(32'd32768, 32'd0);
    send_sample(16'd7, NEW_WINDOW);
    send_sample(16'd8, SAME_WINDOW);

    // Smallest step hits the per-input output cap; the phase then clamps to zero.
    configure(32'd1, 32'd16384);
    send_sample(16'h7FFF, NEW_WINDOW);
    send_sample(16'h8000, SAME_WINDOW);

    // Largest step with a window length beyond the hardware maximum.
    configure(32'd262143, 32'd32767);
    send_sample(16'd1000, NEW_WINDOW);
    send_sample(-16'sd1000, SAME_WINDOW);
    send_sample(16'd2000, SAME_WINDOW);
    send_sample(-16'sd2000, SAME_WINDOW);
    send_sample(16'h7FFF, SAME_WINDOW);

    // Unit step with a tiny window.
    configure(32'd65536, 32'd3);
    send_sample(16'd5, NEW_WINDOW);
    send_sample(16'd6, SAME_WINDOW);
    send_sample(16'd7, SAME_WINDOW);
    send_sample(16'd8, SAME_WINDOW);

    // Random phases, each opening a fresh window and restarting now and then.
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      step = pick_step();
      wlen = pick_wlen();
      if (ph == 1) begin
        step = $urandom_range(70000, 20000);
        wlen = 32'd16384;
      end
      configure(step, wlen);
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 64; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 64; end
        default: begin tx_idle_pct = 35; rx_stall_pct = 35; end
      endcase
      // Output side holds off long enough for the input side to back up.
      if (ph == 1) rx_hold_req = HOLD_CYCLES;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 3 && k == PHASE_ITEMS / 2) settle();
        send_sample(pick_sample(), (k == 0) || ($urandom_range(99) < 8));
      end
    end

    // Drain with the output side always ready.
    s_tvalid <= 1'b0;
    rx_stall_pct = 0;
    tx_idle_pct  = 0;
    for (waited = 0; waited < DRAIN_LIMIT && outputs_owed != 0; waited++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && outputs_owed == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule
